[rtl/core/voxel_face_visibility_assert.svh]
// Assertion macros shared by the voxel face visibility checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef VOXEL_FACE_VISIBILITY_ASSERT_SVH
`define VOXEL_FACE_VISIBILITY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VFV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel_face_visibility check failed");

// Next-cycle implication, disabled during reset.
`define VFV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel_face_visibility check failed");

`endif

[rtl/core/vfv_pkg.sv]
// Shared types and constants for the voxel face visibility block.
// No dependencies; used by vfv_ctrl, vfv_datapath and the top level.
package vfv_pkg;

    // Transaction kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Block types
    localparam logic [1:0] BT_AIR      = 2'd0;
    localparam logic [1:0] BT_STONE    = 2'd1;
    localparam logic [1:0] BT_AMETHYST = 2'd2;
    localparam logic [1:0] BT_OTHER    = 2'd3;

    // Texture indices
    localparam logic [7:0] TEX_STONE    = 8'd1;
    localparam logic [7:0] TEX_AMETHYST = 8'd0;
    localparam logic [7:0] NO_TEXTURE   = 8'd255;

    // Read slots of a query: center, then neighbors in face-mask order
    localparam logic [2:0] NB_CENTER = 3'd0;
    localparam logic [2:0] NB_PX     = 3'd1;
    localparam logic [2:0] NB_PY     = 3'd2;
    localparam logic [2:0] NB_NX     = 3'd3;
    localparam logic [2:0] NB_NY     = 3'd4;
    localparam logic [2:0] NB_PZ     = 3'd5;
    localparam logic [2:0] NB_NZ     = 3'd6;
    localparam logic [2:0] LAST_STEP = 3'd7;

    // Face mask bit positions
    localparam int FACE_PX = 0;
    localparam int FACE_PY = 1;
    localparam int FACE_NX = 2;
    localparam int FACE_NY = 3;
    localparam int FACE_PZ = 4;
    localparam int FACE_NZ = 5;

    // Coordinate width inside the datapath: holds edge up to 64 plus wrap
    localparam int CRD_W = 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } vfv_state_t;

    typedef struct packed {
        logic       clear;     // clearing pass write
        logic       capture;   // latch input transaction
        logic       write;     // store captured type at center
        logic       issue;     // memory read for slot idx
        logic [2:0] idx;       // slot addressed this cycle
        logic       consume;   // read data of slot cidx is available
        logic [2:0] cidx;
        logic       load_out;  // load result register
    } vfv_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_valid;
    } vfv_status_t;

    function automatic logic [7:0] texture_of(input logic [1:0] bt);
        logic [7:0] tex;
        case (bt)
            BT_STONE:    tex = TEX_STONE;
            BT_AMETHYST: tex = TEX_AMETHYST;
            default:     tex = NO_TEXTURE;
        endcase
        return tex;
    endfunction

endpackage

[rtl/core/vfv_ctrl.sv]
// Controller state machine for the voxel face visibility block.
// Depends on vfv_pkg; drives vfv_datapath through vfv_cmd_t.
module vfv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 kind,
    input  logic                 out_ready,
    input  vfv_pkg::vfv_status_t status,
    output logic                 in_ready,
    output vfv_pkg::vfv_cmd_t    cmd
);

    vfv_pkg::vfv_state_t state_reg, state_next;
    logic [2:0]          step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vfv_pkg::ST_CLEAR;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            vfv_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = vfv_pkg::ST_IDLE;
            end
            vfv_pkg::ST_IDLE:
            begin
                step_next = 3'd0;
                if (in_valid)
                    state_next = (kind == vfv_pkg::KIND_QUERY) ? vfv_pkg::ST_READ
                                                               : vfv_pkg::ST_WRITE;
            end
            vfv_pkg::ST_WRITE:
                state_next = vfv_pkg::ST_IDLE;
            vfv_pkg::ST_READ:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == vfv_pkg::LAST_STEP)
                    state_next = vfv_pkg::ST_DONE;
            end
            vfv_pkg::ST_DONE:
            begin
                if (!status.out_valid || out_ready)
                    state_next = vfv_pkg::ST_IDLE;
            end
            default:
                state_next = vfv_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.idx      = vfv_pkg::NB_CENTER;
        cmd.cidx     = vfv_pkg::NB_CENTER;
        case (state_reg)
            vfv_pkg::ST_CLEAR:
                cmd.clear = 1'b1;
            vfv_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            vfv_pkg::ST_WRITE:
                cmd.write = 1'b1;
            vfv_pkg::ST_READ:
            begin
                cmd.issue   = (step_reg != vfv_pkg::LAST_STEP);
                cmd.idx     = step_reg;
                cmd.consume = (step_reg != 3'd0);
                cmd.cidx    = step_reg - 3'd1;
            end
            vfv_pkg::ST_DONE:
                cmd.load_out = !status.out_valid || out_ready;
            default:
                in_ready = 1'b0;
        endcase
    end

endmodule

[rtl/core/vfv_datapath.sv]
// Datapath: voxel store, neighbor addressing, face mask and result register.
// Depends on vfv_pkg; commanded by vfv_ctrl.
module vfv_datapath #(
    parameter int CHUNK_EDGE = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vfv_pkg::vfv_cmd_t    cmd,
    output vfv_pkg::vfv_status_t status,
    input  logic [4:0]           voxel_x,
    input  logic [4:0]           voxel_y,
    input  logic [4:0]           voxel_z,
    input  logic [1:0]           block_type,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [5:0]           face_mask,
    output logic [7:0]           texture_index,
    output logic [1:0]           stored_type
);

    localparam int CW    = (CHUNK_EDGE > 1) ? $clog2(CHUNK_EDGE) : 1;
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 2 ** AW;
    localparam logic [vfv_pkg::CRD_W-1:0] EDGE_C = vfv_pkg::CRD_W'(CHUNK_EDGE);
    localparam logic [vfv_pkg::CRD_W-1:0] CRD_ONE = vfv_pkg::CRD_W'(1);
    localparam logic [AW-1:0]             CNT_ONE = AW'(1);

    // Captured transaction
    logic [4:0] x_reg, y_reg, z_reg;
    logic [1:0] bt_reg;

    // Store
    logic [1:0]    voxel_mem_reg [DEPTH];
    logic [1:0]    rd_data_reg;
    logic          outside_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Query accumulation and result
    logic [1:0] center_type_reg;
    logic [5:0] mask_reg;
    logic       out_valid_reg, out_valid_next;
    logic [5:0] face_mask_reg;
    logic [7:0] texture_index_reg;
    logic [1:0] stored_type_reg;

    logic [vfv_pkg::CRD_W-1:0] cx, cy, cz, nx, ny, nz;
    logic                      in_chunk;
    logic [AW-1:0]             addr;
    logic                      mem_we;
    logic [1:0]                mem_wdata;
    logic                      nb_open;

    assign cx = vfv_pkg::CRD_W'(x_reg);
    assign cy = vfv_pkg::CRD_W'(y_reg);
    assign cz = vfv_pkg::CRD_W'(z_reg);

    // Neighbor coordinates; below-zero wraps high and fails the bound check
    always_comb
    begin
        nx = cx;
        ny = cy;
        nz = cz;
        case (cmd.idx)
            vfv_pkg::NB_PX: nx = cx + CRD_ONE;
            vfv_pkg::NB_PY: ny = cy + CRD_ONE;
            vfv_pkg::NB_NX: nx = cx - CRD_ONE;
            vfv_pkg::NB_NY: ny = cy - CRD_ONE;
            vfv_pkg::NB_PZ: nz = cz + CRD_ONE;
            vfv_pkg::NB_NZ: nz = cz - CRD_ONE;
            default:        nx = cx;
        endcase
    end

    assign in_chunk = (nx < EDGE_C) && (ny < EDGE_C) && (nz < EDGE_C);

    always_comb
    begin
        if (cmd.clear)
            addr = clr_cnt_reg;
        else
            addr = {nz[CW-1:0], ny[CW-1:0], nx[CW-1:0]};
    end

    assign mem_we    = cmd.clear || (cmd.write && in_chunk);
    assign mem_wdata = cmd.clear ? vfv_pkg::BT_AIR : bt_reg;

    // Single-port store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            voxel_mem_reg[addr] <= mem_wdata;
        if (cmd.issue)
        begin
            rd_data_reg <= voxel_mem_reg[addr];
            outside_reg <= !in_chunk;
        end
    end

    assign clr_cnt_next = cmd.clear ? clr_cnt_reg + CNT_ONE : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign nb_open = outside_reg || (rd_data_reg == vfv_pkg::BT_AIR);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg  <= voxel_x;
            y_reg  <= voxel_y;
            z_reg  <= voxel_z;
            bt_reg <= block_type;
        end
        if (cmd.consume)
        begin
            case (cmd.cidx)
                vfv_pkg::NB_CENTER: center_type_reg <= outside_reg ? vfv_pkg::BT_AIR
                                                                   : rd_data_reg;
                vfv_pkg::NB_PX: mask_reg[vfv_pkg::FACE_PX] <= nb_open;
                vfv_pkg::NB_PY: mask_reg[vfv_pkg::FACE_PY] <= nb_open;
                vfv_pkg::NB_NX: mask_reg[vfv_pkg::FACE_NX] <= nb_open;
                vfv_pkg::NB_NY: mask_reg[vfv_pkg::FACE_NY] <= nb_open;
                vfv_pkg::NB_PZ: mask_reg[vfv_pkg::FACE_PZ] <= nb_open;
                vfv_pkg::NB_NZ: mask_reg[vfv_pkg::FACE_NZ] <= nb_open;
                default:        center_type_reg <= center_type_reg;
            endcase
        end
        if (cmd.load_out)
        begin
            face_mask_reg     <= (center_type_reg == vfv_pkg::BT_AIR) ? 6'd0 : mask_reg;
            texture_index_reg <= vfv_pkg::texture_of(center_type_reg);
            stored_type_reg   <= center_type_reg;
        end
    end

    assign status.clear_last = (clr_cnt_reg == {AW{1'b1}});
    assign status.out_valid  = out_valid_reg;

    assign out_valid     = out_valid_reg;
    assign face_mask     = face_mask_reg;
    assign texture_index = texture_index_reg;
    assign stored_type   = stored_type_reg;

endmodule

[rtl/core/voxel_face_visibility.sv]
// A write is stored in the WRITE state that follows its accepting edge; a query result
// is loaded from the DONE state after the read walk, once the result register is free.
// Transactions are handled one at a time; a query makes seven serial reads (center
// plus six neighbors) on the single-port voxel store.
// Reset: async active-low; control clears, then a clearing pass writes air to every
// entry of the store, with in_ready low.
//
// Top level of the voxel face visibility block. Depends on vfv_pkg, vfv_ctrl and
// vfv_datapath. The store is addressed as {z, y, x}, each clog2(CHUNK_EDGE) bits.
module voxel_face_visibility #(
    parameter int CHUNK_EDGE = 32
) (
    input  logic       clk,
    input  logic       rst_n,

    // Input transaction
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [4:0] voxel_x,
    input  logic [4:0] voxel_y,
    input  logic [4:0] voxel_z,
    input  logic [1:0] block_type,

    // Result transaction (queries only)
    output logic       out_valid,
    input  logic       out_ready,
    output logic [5:0] face_mask,
    output logic [7:0] texture_index,
    output logic [1:0] stored_type
);

    vfv_pkg::vfv_cmd_t    cmd;
    vfv_pkg::vfv_status_t status;

    // Sequencer: clearing pass, capture, write, seven-slot read walk, result load.
    // A query whose result register is still occupied waits in its last state.
    vfv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // Store, neighbor address generation, mask build and output register.
    // Neighbors outside the chunk count as air; an out-of-chunk write is dropped.
    vfv_datapath #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .voxel_x       (voxel_x),
        .voxel_y       (voxel_y),
        .voxel_z       (voxel_z),
        .block_type    (block_type),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .face_mask     (face_mask),
        .texture_index (texture_index),
        .stored_type   (stored_type)
    );

endmodule

[rtl/core/vfv_checker.sv]
// Port-level checks for voxel_face_visibility, attached with bind.
// Depends on vfv_pkg and voxel_face_visibility_assert.svh.
`include "voxel_face_visibility_assert.svh"

module vfv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] face_mask,
    input logic [7:0] texture_index,
    input logic [1:0] stored_type
);

    // A stalled result stays valid
    `VFV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // A stalled result keeps its payload
    `VFV_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(face_mask) && $stable(texture_index) && $stable(stored_type))

    // Air has no faces and no texture
    `VFV_ASSERT_SAME(a_air_result, out_valid && stored_type == vfv_pkg::BT_AIR, face_mask == 6'd0 && texture_index == vfv_pkg::NO_TEXTURE)

    // One transaction at a time: busy right after an accept
    `VFV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .face_mask     (face_mask),
    .texture_index (texture_index),
    .stored_type   (stored_type)
);
